// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside of reset.
`define FFBA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("allocator assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define FFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`else

`define FFBA_ASSERT(lbl, clk, rst_n, prop)
`define FFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/ffba_pkg.sv -----
package ffba_pkg;

    // Operation codes of an input word
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_NO_FIT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    // Fixed field widths of the port words
    localparam int SIZE_W   = 16;
    localparam int INDEX_W  = 4;
    localparam int SERIAL_W = 16;

    typedef struct packed {
        logic              operation;
        logic [SIZE_W-1:0] size;
    } t_in_word;

    typedef struct packed {
        t_status             status;
        logic [INDEX_W-1:0]  block_index;
        logic [SIZE_W-1:0]   remaining;
        logic [SERIAL_W-1:0] alloc_serial;
    } t_out_word;

    // Control part of a request travelling down the cell chain
    typedef struct packed {
        logic valid;  // slot holds a request
        logic op;     // OP_ADD or OP_ALLOC
        logic done;   // some cell already served it
    } t_tok_ctl;

endpackage

// ----- sv/ffba_cell.sv -----
`include "assert_macros.svh"

module ffba_cell #(
    parameter int SIZE_BITS = 16,
    parameter int IDX_W     = 4,
    parameter int CELL_IDX  = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  ffba_pkg::t_tok_ctl    i_ctl,
    input  logic [SIZE_BITS-1:0]  i_data,
    input  logic [IDX_W-1:0]      i_idx,
    output ffba_pkg::t_tok_ctl    o_ctl,
    output logic [SIZE_BITS-1:0]  o_data,
    output logic [IDX_W-1:0]      o_idx
);
    import ffba_pkg::*;

    localparam logic [IDX_W-1:0] CELL_ID = IDX_W'(CELL_IDX);

    // Block held by this cell
    logic                 r_used, n_used;
    logic [SIZE_BITS-1:0] r_size, n_size;

    // Request register handed to the next cell
    t_tok_ctl             r_ctl, n_ctl;
    logic [SIZE_BITS-1:0] r_data, n_data;
    logic [IDX_W-1:0]     r_idx, n_idx;

    logic                 fit;
    logic [SIZE_BITS-1:0] diff;

    // Request data is the size until served, the remainder after an allocation
    assign fit  = r_used && (i_data <= r_size);
    assign diff = r_size - i_data;

    // Serve an unserved request if this cell qualifies
    always_comb begin
        n_used = r_used;
        n_size = r_size;
        n_ctl  = i_ctl;
        n_data = i_data;
        n_idx  = i_idx;
        if (i_ctl.valid && !i_ctl.done) begin
            if (i_ctl.op == OP_ADD && !r_used) begin
                n_used     = 1'b1;
                n_size     = i_data;
                n_ctl.done = 1'b1;
                n_idx      = CELL_ID;
            end else if (i_ctl.op == OP_ALLOC && fit) begin
                n_size     = diff;
                n_data     = diff;
                n_ctl.done = 1'b1;
                n_idx      = CELL_ID;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_ctl  <= '0;
        end else if (i_en) begin
            r_used <= n_used;
            r_ctl  <= n_ctl;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_size <= n_size;
            r_data <= n_data;
            r_idx  <= n_idx;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_data = r_data;
    assign o_idx  = r_idx;

    // A block once added is never released
    `FFBA_ASSERT_NEXT(a_used_sticky, i_clk, i_rst_n, r_used, r_used)

    // A free cell takes the first unserved add that reaches it
    `FFBA_ASSERT_NEXT(a_add_claims, i_clk, i_rst_n,
        i_en && i_ctl.valid && !i_ctl.done && i_ctl.op == OP_ADD && !r_used,
        r_used && o_ctl.done && o_idx == CELL_ID)

    // A served request passes through untouched
    `FFBA_ASSERT_NEXT(a_done_pass, i_clk, i_rst_n,
        i_en && i_ctl.valid && i_ctl.done,
        o_ctl.done && o_idx == $past(i_idx) && o_data == $past(i_data))

    // Nothing moves while the chain is stalled
    `FFBA_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n,
        !i_en, $stable(r_used) && $stable(r_ctl))

endmodule

// ----- sv/ffba_out.sv -----
`include "assert_macros.svh"

module ffba_out #(
    parameter int SIZE_BITS = 16,
    parameter int IDX_W     = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ffba_pkg::t_tok_ctl    i_ctl,
    input  logic [SIZE_BITS-1:0]  i_data,
    input  logic [IDX_W-1:0]      i_idx,
    output logic                  o_en,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ffba_pkg::t_out_word   o_out_word
);
    import ffba_pkg::*;

    logic                r_valid;
    t_out_word           r_word, n_word;
    logic [SERIAL_W-1:0] r_serial;
    logic                take_alloc;

    // Chain advances whenever the output register can take a word
    assign o_en = !r_valid || i_out_ready;

    assign take_alloc = o_en && i_ctl.valid && i_ctl.done && i_ctl.op == OP_ALLOC;

    // Build the result word from the request leaving the last cell
    always_comb begin
        n_word = '0;
        if (!i_ctl.done) begin
            n_word.status = (i_ctl.op == OP_ADD) ? ST_FULL : ST_NO_FIT;
        end else begin
            n_word.status      = ST_DONE;
            n_word.block_index = INDEX_W'(i_idx);
            n_word.remaining   = SIZE_W'(i_data);
            if (i_ctl.op == OP_ALLOC) begin
                n_word.alloc_serial = r_serial;
            end
        end
    end

    // Output valid and allocation serial
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_serial <= '0;
        end else begin
            if (o_en) begin
                r_valid <= i_ctl.valid;
            end
            if (take_alloc) begin
                r_serial <= r_serial + 1'b1;
            end
        end
    end

    // Output word
    always_ff @(posedge i_clk) begin
        if (o_en && i_ctl.valid) begin
            r_word <= n_word;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

    // Serial steps only on a served allocation
    `FFBA_ASSERT_NEXT(a_serial_step, i_clk, i_rst_n, take_alloc,
        r_serial == $past(r_serial) + 1'b1)
    `FFBA_ASSERT_NEXT(a_serial_hold, i_clk, i_rst_n, !take_alloc, $stable(r_serial))

endmodule

// ----- sv/first_fit_block_allocator_top.sv -----
// First-fit block allocator. Each input word either adds a free block of the
// given size to the table or allocates from the first block, in insertion
// order, that is large enough; every word yields exactly one result word.
// The table is a chain of MAX_BLOCKS cells, one block per cell, and each
// request walks the chain one cell per clock unless the chain is stalled;
// the result is then registered in the output register. Requests follow
// one another one cell apart, so the block takes one word per cycle as long
// as results are drained; a full output register stalls the whole chain. The
// allocation serial counts successful allocations and wraps at 16 bits.
module first_fit_block_allocator_top #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ffba_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ffba_pkg::t_out_word  o_out_word
);
    import ffba_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    logic                 en;
    t_tok_ctl             link_ctl  [MAX_BLOCKS+1];
    logic [SIZE_BITS-1:0] link_data [MAX_BLOCKS+1];
    logic [IDX_W-1:0]     link_idx  [MAX_BLOCKS+1];

    assign o_in_ready = en;

    // Request entering the chain
    assign link_ctl[0]  = '{valid: i_in_valid, op: i_in_word.operation, done: 1'b0};
    assign link_data[0] = SIZE_BITS'(i_in_word.size);
    assign link_idx[0]  = '0;

    // Cell chain
    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        ffba_cell #(
            .SIZE_BITS (SIZE_BITS),
            .IDX_W     (IDX_W),
            .CELL_IDX  (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (link_ctl[g]),
            .i_data  (link_data[g]),
            .i_idx   (link_idx[g]),
            .o_ctl   (link_ctl[g+1]),
            .o_data  (link_data[g+1]),
            .o_idx   (link_idx[g+1])
        );
    end

    // Result formatting and output register
    ffba_out #(
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W)
    ) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (link_ctl[MAX_BLOCKS]),
        .i_data      (link_data[MAX_BLOCKS]),
        .i_idx       (link_idx[MAX_BLOCKS]),
        .o_en        (en),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
